@@ design/svm_exec_pkg.sv @@
package svm_exec_pkg;

  localparam int STACK_DEPTH_DEF  = 1024;
  localparam int STATIC_SLOTS_DEF = 256;

  localparam logic [7:0] BYTE_MASK = 8'hff;
  localparam int         BYTE_BITS = 8;

  localparam logic [4:0] OP_PUSH_BYTE = 5'd0;
  localparam logic [4:0] OP_PUSH_WORD = 5'd1;
  localparam logic [4:0] OP_POP_STAT  = 5'd2;
  localparam logic [4:0] OP_PUSH_STAT = 5'd3;
  localparam logic [4:0] OP_POP_LOC   = 5'd4;
  localparam logic [4:0] OP_PUSH_LOC  = 5'd5;
  localparam logic [4:0] OP_ADD       = 5'd6;
  localparam logic [4:0] OP_SUB       = 5'd7;
  localparam logic [4:0] OP_MUL       = 5'd8;
  localparam logic [4:0] OP_DIV       = 5'd9;
  localparam logic [4:0] OP_MOD       = 5'd10;
  localparam logic [4:0] OP_NEG       = 5'd11;
  localparam logic [4:0] OP_INC       = 5'd12;
  localparam logic [4:0] OP_DEC       = 5'd13;
  localparam logic [4:0] OP_AND       = 5'd14;
  localparam logic [4:0] OP_OR        = 5'd15;
  localparam logic [4:0] OP_NOT       = 5'd16;
  localparam logic [4:0] OP_EQ        = 5'd17;
  localparam logic [4:0] OP_NE        = 5'd18;
  localparam logic [4:0] OP_GT        = 5'd19;
  localparam logic [4:0] OP_GE        = 5'd20;
  localparam logic [4:0] OP_LT        = 5'd21;
  localparam logic [4:0] OP_LE        = 5'd22;
  localparam logic [4:0] OP_JMP       = 5'd23;
  localparam logic [4:0] OP_JMP_F     = 5'd24;
  localparam logic [4:0] OP_JMP_T     = 5'd25;
  localparam logic [4:0] OP_DUP       = 5'd26;

  localparam logic [2:0] ERR_OK     = 3'd0;
  localparam logic [2:0] ERR_DIV0   = 3'd1;
  localparam logic [2:0] ERR_UNDER  = 3'd2;
  localparam logic [2:0] ERR_OVER   = 3'd3;
  localparam logic [2:0] ERR_STATIC = 3'd4;

  localparam logic CFG_FRAME_BASE = 1'b0;
  localparam logic CFG_PROG_LEN   = 1'b1;

  typedef enum logic [9:0] {
    S_CLR    = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_CHK    = 10'b0000000100,
    S_RD1    = 10'b0000001000,
    S_RD2    = 10'b0000010000,
    S_DIV    = 10'b0000100000,
    S_EXE    = 10'b0001000000,
    S_WR     = 10'b0010000000,
    S_TOPRD  = 10'b0100000000,
    S_TOPDAT = 10'b1000000000
  } state_t;

endpackage

@@ design/stack_vm_integer_execute_core.sv @@
// Integer execute core of a stack bytecode machine.
// Input channel (in_valid / in_stall): one decoded instruction per transfer,
// in_mode and in_operand. Result channel (out_valid / out_stall): one result
// per instruction: next pc, top of stack, depth, done flag and error code.
// Config channel (cfg_valid / cfg_ready): index 0 frame base, 1 program length;
// always ready; the user must write it only while the core is idle (not enforced).
// Stack and statics live in single-port-write, one-read synchronous memories.
// Path from input transfer to result: an instruction that fails its checks
// or arrives once done goes CHK, TOPRD, TOPDAT; immediate pushes, JMP and
// no-ops go CHK, EXE, WR, TOPRD, TOPDAT; one-operand ops, pops, conditional
// jumps, memory pushes and dup add RD1 before EXE; two-operand ops add RD1
// and RD2 (a zero divisor goes from RD2 to TOPRD); div and mod also pass DIV,
// the one-bit-per-cycle divider. One instruction is in flight at a time;
// the next is taken once the previous result sits in the output register.
// After reset a clearing pass zeroes both memories at addresses 0 to
// max(STACK_DEPTH, STATIC_SLOTS) - 1; in_stall stays high meanwhile.
// A stalled result holds the output register; the core finishes the next
// instruction and then waits until the register is free.
module stack_vm_integer_execute_core
  import svm_exec_pkg::*;
#(
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
  parameter int STATIC_SLOTS = STATIC_SLOTS_DEF,
  localparam int SAW = $clog2(STACK_DEPTH),
  localparam int TW  = SAW + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [4:0]    in_mode,
  input  logic [15:0]   in_operand,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [15:0]   out_next_pc,
  output logic [31:0]   out_top_value,
  output logic [TW-1:0] out_stack_depth,
  output logic          out_done_res,
  output logic [2:0]    out_error,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data
);

  localparam int SIW   = (STATIC_SLOTS > 1) ? $clog2(STATIC_SLOTS) : 1;
  localparam int CLR_N = (STACK_DEPTH > STATIC_SLOTS) ? STACK_DEPTH : STATIC_SLOTS;
  localparam int CW    = $clog2(CLR_N + 1);

  localparam logic [TW-1:0] DEPTH_T  = TW'(STACK_DEPTH);
  localparam logic [17:0]   DEPTH_18 = 18'(STACK_DEPTH);
  localparam logic [16:0]   STAT_17  = 17'(STATIC_SLOTS);
  localparam logic [CW-1:0] CLR_LAST = CW'(CLR_N - 1);

  logic [31:0] stk_mem [STACK_DEPTH];
  logic [31:0] sta_mem [STATIC_SLOTS];

  state_t state_r, state_nxt;

  logic [9:0]    fbase_r;
  logic [15:0]   plen_r;
  logic [TW-1:0] top_r;
  logic [15:0]   pc_r;
  logic [CW-1:0] clr_r;

  logic [4:0]  op_r;
  logic [15:0] opnd_r;
  logic [31:0] a_r, b_r, res_r;
  logic [2:0]  err_r;
  logic [SAW-1:0] wr_addr_r;
  logic        wr_stk_r, wr_sta_r;
  logic [TW-1:0] ntop_r;
  logic [15:0] npc_r;

  logic [31:0] dvd_r, dvs_r;
  logic [32:0] rem_r;
  logic [4:0]  dcnt_r;

  logic [31:0] stk_rdata_r, sta_rdata_r;

  logic          stk_we, stk_re, sta_we, sta_re;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  logic [SIW-1:0] sta_waddr;
  logic [31:0]   stk_wdata, sta_wdata;

  logic [16:0]   slot_c;
  logic [2:0]    err_c;
  logic          bin_c, div_c;
  logic [32:0]   rem_s;
  logic [31:0]   res_c;
  logic [TW-1:0] ntop_c;
  logic [15:0]   npc_c;
  logic [SAW-1:0] wa_c;
  logic          wstk_c;
  logic [63:0]   prod_c;
  logic          out_valid_r;
  logic          out_load;

  assign slot_c = {7'd0, fbase_r} + {1'b0, opnd_r};
  assign bin_c  = (op_r >= OP_ADD && op_r <= OP_MOD) || op_r == OP_AND || op_r == OP_OR ||
                  (op_r >= OP_EQ && op_r <= OP_LE);
  assign div_c  = (op_r == OP_DIV) || (op_r == OP_MOD);
  assign rem_s  = {rem_r[31:0], dvd_r[31]};
  assign prod_c = a_r * b_r;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_load  = (state_r == S_TOPDAT) && (!out_valid_r || !out_stall);

  // checks made in S_CHK, before any write back
  always_comb begin
    err_c = ERR_OK;
    case (op_r) inside
      OP_PUSH_BYTE, OP_PUSH_WORD, OP_PUSH_STAT, OP_PUSH_LOC, OP_DUP: begin
        if (op_r == OP_DUP && top_r == '0) err_c = ERR_UNDER;
        else if (top_r >= DEPTH_T) err_c = ERR_OVER;
      end
      OP_POP_STAT, OP_POP_LOC, OP_NEG, OP_INC, OP_DEC, OP_NOT, OP_JMP_F, OP_JMP_T: begin
        if (top_r == '0) err_c = ERR_UNDER;
      end
      default: begin
        if (bin_c && top_r < TW'(2)) err_c = ERR_UNDER;
      end
    endcase
    if (err_c == ERR_OK) begin
      if ((op_r == OP_POP_STAT || op_r == OP_PUSH_STAT) && {1'b0, opnd_r} >= STAT_17)
        err_c = ERR_STATIC;
      else if ((op_r == OP_POP_LOC || op_r == OP_PUSH_LOC) && {1'b0, slot_c} >= DEPTH_18)
        err_c = ERR_OVER;
    end
  end

  // execute
  always_comb begin
    res_c  = b_r;
    ntop_c = top_r;
    npc_c  = pc_r + 16'd1;
    wa_c   = SAW'(top_r - TW'(1));
    wstk_c = 1'b0;
    case (op_r) inside
      OP_PUSH_BYTE: begin
        res_c  = {24'd0, opnd_r[BYTE_BITS-1:0] & BYTE_MASK};
        ntop_c = top_r + TW'(1);
        npc_c  = pc_r + 16'd2;
        wa_c   = SAW'(top_r);
        wstk_c = 1'b1;
      end
      OP_PUSH_WORD, OP_PUSH_STAT, OP_PUSH_LOC: begin
        res_c  = (op_r == OP_PUSH_WORD) ? {16'd0, opnd_r} : b_r;
        ntop_c = top_r + TW'(1);
        npc_c  = pc_r + 16'd3;
        wa_c   = SAW'(top_r);
        wstk_c = 1'b1;
      end
      OP_DUP: begin
        ntop_c = top_r + TW'(1);
        wa_c   = SAW'(top_r);
        wstk_c = 1'b1;
      end
      OP_POP_STAT: begin
        ntop_c = top_r - TW'(1);
        npc_c  = pc_r + 16'd3;
      end
      OP_POP_LOC: begin
        ntop_c = top_r - TW'(1);
        npc_c  = pc_r + 16'd3;
        wa_c   = slot_c[SAW-1:0];
        wstk_c = 1'b1;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR,
      OP_EQ, OP_NE, OP_GT, OP_GE, OP_LT, OP_LE: begin
        ntop_c = top_r - TW'(1);
        wa_c   = SAW'(top_r - TW'(2));
        wstk_c = 1'b1;
        case (op_r)
          OP_ADD:  res_c = a_r + b_r;
          OP_SUB:  res_c = a_r - b_r;
          OP_MUL:  res_c = prod_c[31:0];
          OP_DIV:  res_c = (a_r[31] ^ b_r[31]) ? (32'd0 - dvd_r) : dvd_r;
          OP_MOD:  res_c = a_r[31] ? (32'd0 - rem_r[31:0]) : rem_r[31:0];
          OP_AND:  res_c = {31'd0, (a_r != 32'd0) && (b_r != 32'd0)};
          OP_OR:   res_c = {31'd0, (a_r != 32'd0) || (b_r != 32'd0)};
          OP_EQ:   res_c = {31'd0, a_r == b_r};
          OP_NE:   res_c = {31'd0, a_r != b_r};
          OP_GT:   res_c = {31'd0, $signed(b_r) < $signed(a_r)};
          OP_GE:   res_c = {31'd0, !($signed(a_r) < $signed(b_r))};
          OP_LT:   res_c = {31'd0, $signed(a_r) < $signed(b_r)};
          default: res_c = {31'd0, !($signed(b_r) < $signed(a_r))};
        endcase
      end
      OP_NEG: begin res_c = 32'd0 - b_r; wstk_c = 1'b1; end
      OP_INC: begin res_c = b_r + 32'd1; wstk_c = 1'b1; end
      OP_DEC: begin res_c = b_r - 32'd1; wstk_c = 1'b1; end
      OP_NOT: begin res_c = {31'd0, b_r == 32'd0}; wstk_c = 1'b1; end
      OP_JMP: npc_c = opnd_r;
      OP_JMP_F, OP_JMP_T: begin
        ntop_c = top_r - TW'(1);
        npc_c  = ((op_r == OP_JMP_F) == (b_r == 32'd0)) ? opnd_r : pc_r + 16'd3;
      end
      default: ;
    endcase
  end

  // memory ports
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = wr_addr_r;
    stk_wdata = res_r;
    sta_we    = 1'b0;
    sta_waddr = opnd_r[SIW-1:0];
    sta_wdata = res_r;
    stk_re    = 1'b0;
    stk_raddr = SAW'(top_r - TW'(1));
    sta_re    = 1'b0;
    unique case (state_r)
      S_CLR: begin
        stk_we    = (32'(clr_r) < STACK_DEPTH);
        stk_waddr = SAW'(clr_r);
        stk_wdata = '0;
        sta_we    = (32'(clr_r) < STATIC_SLOTS);
        sta_waddr = SIW'(clr_r);
        sta_wdata = '0;
      end
      S_CHK: begin
        stk_re = 1'b1;
        if (op_r == OP_PUSH_LOC) stk_raddr = slot_c[SAW-1:0];
        sta_re = (op_r == OP_PUSH_STAT) && ({1'b0, opnd_r} < STAT_17);
      end
      S_RD1: begin
        stk_re    = 1'b1;
        stk_raddr = SAW'(top_r - TW'(2));
      end
      S_WR: begin
        stk_we = wr_stk_r;
        sta_we = wr_sta_r;
      end
      S_TOPRD: stk_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_rdata_r <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (sta_we) sta_mem[sta_waddr] <= sta_wdata;
    if (sta_re) sta_rdata_r <= sta_mem[opnd_r[SIW-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR:    if (clr_r == CLR_LAST) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_CHK;
      S_CHK: begin
        if (pc_r >= plen_r || err_c != ERR_OK) state_nxt = S_TOPRD;
        else if (op_r == OP_PUSH_BYTE || op_r == OP_PUSH_WORD || op_r == OP_JMP ||
                 op_r > OP_DUP) state_nxt = S_EXE;
        else state_nxt = S_RD1;
      end
      S_RD1:    state_nxt = bin_c ? S_RD2 : S_EXE;
      S_RD2: begin
        if (div_c && b_r == 32'd0) state_nxt = S_TOPRD;
        else if (div_c) state_nxt = S_DIV;
        else state_nxt = S_EXE;
      end
      S_DIV:    if (dcnt_r == 5'd31) state_nxt = S_EXE;
      S_EXE:    state_nxt = S_WR;
      S_WR:     state_nxt = S_TOPRD;
      S_TOPRD:  state_nxt = S_TOPDAT;
      S_TOPDAT: if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      fbase_r     <= '0;
      plen_r      <= '0;
      top_r       <= '0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      wr_stk_r    <= 1'b0;
      wr_sta_r    <= 1'b0;
      err_r       <= ERR_OK;
      dcnt_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FRAME_BASE) fbase_r <= cfg_data[9:0];
        else plen_r <= cfg_data;
      end
      if (state_r == S_CLR) clr_r <= clr_r + CW'(1);
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (out_load) out_valid_r <= 1'b1;
      unique case (state_r)
        S_IDLE: begin
          op_r   <= in_mode;
          opnd_r <= in_operand;
          err_r  <= ERR_OK;
        end
        S_CHK: if (pc_r < plen_r) err_r <= err_c;
        S_RD1: b_r <= (op_r == OP_PUSH_STAT) ? sta_rdata_r : stk_rdata_r;
        S_RD2: begin
          a_r    <= stk_rdata_r;
          dvd_r  <= stk_rdata_r[31] ? 32'd0 - stk_rdata_r : stk_rdata_r;
          dvs_r  <= b_r[31] ? 32'd0 - b_r : b_r;
          rem_r  <= '0;
          dcnt_r <= '0;
          if (div_c && b_r == 32'd0) err_r <= ERR_DIV0;
        end
        S_DIV: begin
          dcnt_r <= dcnt_r + 5'd1;
          if (rem_s >= {1'b0, dvs_r}) begin
            rem_r <= rem_s - {1'b0, dvs_r};
            dvd_r <= {dvd_r[30:0], 1'b1};
          end else begin
            rem_r <= rem_s;
            dvd_r <= {dvd_r[30:0], 1'b0};
          end
        end
        S_EXE: begin
          res_r     <= res_c;
          ntop_r    <= ntop_c;
          npc_r     <= npc_c;
          wr_addr_r <= wa_c;
          wr_stk_r  <= wstk_c;
          wr_sta_r  <= (op_r == OP_POP_STAT);
        end
        S_WR: begin
          top_r    <= ntop_r;
          pc_r     <= npc_r;
          wr_stk_r <= 1'b0;
          wr_sta_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_next_pc     <= pc_r;
      out_top_value   <= (top_r == '0) ? 32'd0 : stk_rdata_r;
      out_stack_depth <= top_r;
      out_done_res    <= (pc_r >= plen_r);
      out_error       <= err_r;
    end
  end

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n) top_r <= DEPTH_T)
    else $error("stack top beyond depth");

  a_take_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> state_r == S_CHK)
    else $error("accepted instruction not checked");

  a_sta_we: assert property (@(posedge clk) disable iff (!rst_n)
    (sta_we && state_r != S_CLR) |-> op_r == OP_POP_STAT)
    else $error("static write by wrong op");

  a_err_nochg: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> err_r == ERR_OK)
    else $error("write back after error");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import svm_exec_pkg::*;

  localparam int          STK_N       = 1024;
  localparam int          STAT_N      = 256;
  localparam int          STALL_LIMIT = 20000;
  localparam int          HOLD_LEN    = 300;
  localparam int          FILL_OPS    = 60;
  localparam int          RAND_N      = 22;
  localparam logic [4:0]  OP_UNUSED   = 5'd31;

  typedef struct packed {
    logic [4:0]  mode;
    logic [15:0] operand;
  } insn_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [31:0] top_value;
    logic [10:0] depth;
    logic        done_res;
    logic [2:0]  error;
  } vm_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [4:0] in_mode;
  logic [15:0] in_operand;
  logic out_valid;
  logic out_stall;
  logic [15:0] out_next_pc;
  logic [31:0] out_top_value;
  logic [10:0] out_stack_depth;
  logic out_done_res;
  logic [2:0] out_error;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [15:0] cfg_data;

  insn_t      insn_q[$];
  vm_result_t result_q[$];

  logic [31:0] vm_stack[STK_N];
  logic [31:0] vm_static[STAT_N];
  int          vm_sp;
  logic [15:0] vm_pc;
  logic [9:0]  vm_frame;
  logic [15:0] vm_len;

  int snd_idle;
  int rcv_idle;
  int hold_req;
  int hold_seen;
  int hold_cnt;
  int fail_cnt;
  int insn_cnt;
  int result_cnt;
  int err_seen[5];
  int quiet_cnt;

  stack_vm_integer_execute_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_operand      (in_operand),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_next_pc     (out_next_pc),
    .out_top_value   (out_top_value),
    .out_stack_depth (out_stack_depth),
    .out_done_res    (out_done_res),
    .out_error       (out_error),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  task automatic exec_insn(input logic [4:0] op, input logic [15:0] opnd);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [15:0] npc;
    logic [2:0]  err;
    vm_result_t  res;
    int          d;
    int          slot;
    d   = vm_sp;
    npc = vm_pc + 16'd1;
    err = ERR_OK;
    if (vm_pc < vm_len) begin
      if (op == OP_DUP && d < 1) begin
        err = ERR_UNDER;
      end else if (op inside {OP_PUSH_BYTE, OP_PUSH_WORD, OP_PUSH_STAT, OP_PUSH_LOC, OP_DUP}
                   && d >= STK_N) begin
        err = ERR_OVER;
      end else if (op inside {OP_POP_STAT, OP_POP_LOC, OP_NEG, OP_INC, OP_DEC, OP_NOT,
                              OP_JMP_F, OP_JMP_T} && d < 1) begin
        err = ERR_UNDER;
      end else if (op inside {[OP_ADD:OP_MOD], OP_AND, OP_OR, [OP_EQ:OP_LE]} && d < 2) begin
        err = ERR_UNDER;
      end
      if (err == ERR_OK) begin
        case (op)
          OP_PUSH_BYTE: begin
            vm_stack[d] = {24'd0, opnd[7:0]};
            vm_sp = d + 1;
            npc = vm_pc + 16'd2;
          end
          OP_PUSH_WORD: begin
            vm_stack[d] = {16'd0, opnd};
            vm_sp = d + 1;
            npc = vm_pc + 16'd3;
          end
          OP_POP_STAT, OP_PUSH_STAT: begin
            if (opnd >= STAT_N) begin
              err = ERR_STATIC;
            end else if (op == OP_POP_STAT) begin
              vm_static[opnd[7:0]] = vm_stack[d-1];
              vm_sp = d - 1;
            end else begin
              vm_stack[d] = vm_static[opnd[7:0]];
              vm_sp = d + 1;
            end
            npc = vm_pc + 16'd3;
          end
          OP_POP_LOC, OP_PUSH_LOC: begin
            slot = int'(vm_frame) + int'(opnd);
            if (slot >= STK_N) begin
              err = ERR_OVER;
            end else if (op == OP_POP_LOC) begin
              vm_stack[slot] = vm_stack[d-1];
              vm_sp = d - 1;
            end else begin
              vm_stack[d] = vm_stack[slot];
              vm_sp = d + 1;
            end
            npc = vm_pc + 16'd3;
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR,
          OP_EQ, OP_NE, OP_GT, OP_GE, OP_LT, OP_LE: begin
            a  = vm_stack[d-2];
            b  = vm_stack[d-1];
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            r  = '0;
            case (op)
              OP_ADD: r = a + b;
              OP_SUB: r = a - b;
              OP_MUL: r = a * b;
              OP_DIV: begin
                if (b == 0) err = ERR_DIV0;
                else begin
                  r = ma / mb;
                  if (a[31] ^ b[31]) r = -r;
                end
              end
              OP_MOD: begin
                if (b == 0) err = ERR_DIV0;
                else begin
                  r = ma % mb;
                  if (a[31]) r = -r;
                end
              end
              OP_AND: r = {31'd0, (a != 0) && (b != 0)};
              OP_OR:  r = {31'd0, (a != 0) || (b != 0)};
              OP_EQ:  r = {31'd0, a == b};
              OP_NE:  r = {31'd0, a != b};
              OP_GT:  r = {31'd0, $signed(a) > $signed(b)};
              OP_GE:  r = {31'd0, $signed(a) >= $signed(b)};
              OP_LT:  r = {31'd0, $signed(a) < $signed(b)};
              default: r = {31'd0, $signed(a) <= $signed(b)};
            endcase
            if (err == ERR_OK) begin
              vm_stack[d-2] = r;
              vm_sp = d - 1;
            end
          end
          OP_NEG: vm_stack[d-1] = -vm_stack[d-1];
          OP_INC: vm_stack[d-1] = vm_stack[d-1] + 32'd1;
          OP_DEC: vm_stack[d-1] = vm_stack[d-1] - 32'd1;
          OP_NOT: vm_stack[d-1] = {31'd0, vm_stack[d-1] == 0};
          OP_JMP: npc = opnd;
          OP_JMP_F, OP_JMP_T: begin
            a = vm_stack[d-1];
            npc = ((op == OP_JMP_F) == (a == 0)) ? opnd : vm_pc + 16'd3;
            vm_sp = d - 1;
          end
          OP_DUP: begin
            vm_stack[d] = vm_stack[d-1];
            vm_sp = d + 1;
          end
          default: ;
        endcase
      end
      if (err == ERR_OK) vm_pc = npc;
    end
    res.next_pc   = vm_pc;
    res.top_value = (vm_sp > 0) ? vm_stack[vm_sp-1] : 32'd0;
    res.depth     = vm_sp[10:0];
    res.done_res  = vm_pc >= vm_len;
    res.error     = err;
    result_q.push_back(res);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_cnt++;
    $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want, result_cnt);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        exec_insn(in_mode, in_operand);
        void'(insn_q.pop_front());
        insn_cnt++;
      end
      if (!(in_valid && in_stall)) begin
        if (insn_q.size() > 0 && $urandom_range(1, 100) > snd_idle) begin
          in_valid   <= 1'b1;
          in_mode    <= insn_q[0].mode;
          in_operand <= insn_q[0].operand;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    vm_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      result_cnt++;
      if (result_q.size() == 0) begin
        fail_cnt++;
        $display("MISMATCH unexpected result %0d", result_cnt);
      end else begin
        want = result_q.pop_front();
        if (out_error < 5) err_seen[out_error]++;
        if (out_next_pc !== want.next_pc)
          report_mismatch("next_pc", 32'(out_next_pc), 32'(want.next_pc));
        if (out_top_value !== want.top_value)
          report_mismatch("top_value", out_top_value, want.top_value);
        if (out_stack_depth !== want.depth)
          report_mismatch("stack_depth", 32'(out_stack_depth), 32'(want.depth));
        if (out_done_res !== want.done_res)
          report_mismatch("done_res", 32'(out_done_res), 32'(want.done_res));
        if (out_error !== want.error)
          report_mismatch("error", 32'(out_error), 32'(want.error));
      end
    end
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_cnt  = HOLD_LEN;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(1, 100) <= rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cnt = 0;
      else
        quiet_cnt++;
      if (quiet_cnt >= STALL_LIMIT) begin
        $display("Timeout: %0d cycles without a transfer", quiet_cnt);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic cfg_write(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_FRAME_BASE) vm_frame = val[9:0];
    else vm_len = val;
  endtask

  task automatic drain();
    while (insn_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic add_insn(input logic [4:0] op, input logic [15:0] opnd);
    insn_t it;
    it.mode    = op;
    it.operand = opnd;
    insn_q.push_back(it);
  endtask

  task automatic add_random();
    int          sel;
    logic [4:0]  op;
    logic [15:0] opnd;
    sel  = int'($urandom_range(0, 99));
    opnd = 16'($urandom_range(0, 65535));
    if (sel < 30) begin
      case ($urandom_range(0, 4))
        0: op = OP_PUSH_BYTE;
        1: op = OP_PUSH_WORD;
        2: op = OP_PUSH_STAT;
        3: op = OP_PUSH_LOC;
        default: op = OP_DUP;
      endcase
    end else if (sel < 38) begin
      op = OP_JMP + 5'($urandom_range(0, 2));
    end else if (sel < 93) begin
      op = 5'($urandom_range(OP_POP_STAT, OP_DUP));
    end else begin
      op = 5'($urandom_range(0, 31));
    end
    if (op inside {OP_POP_STAT, OP_PUSH_STAT} && $urandom_range(0, 9) != 0)
      opnd = 16'($urandom_range(0, STAT_N - 1));
    if (op inside {OP_POP_LOC, OP_PUSH_LOC} && $urandom_range(0, 9) != 0)
      opnd = 16'($urandom_range(0, 15));
    if (op inside {[OP_JMP:OP_JMP_T]} && $urandom_range(0, 19) != 0)
      opnd = (vm_len > 1) ? 16'($urandom_range(0, vm_len - 2)) : 16'd0;
    add_insn(op, opnd);
  endtask

  initial begin
    int p;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_mode    = '0;
    in_operand = '0;
    out_stall  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = 1'b0;
    cfg_data   = '0;
    snd_idle   = 0;
    rcv_idle   = 0;
    hold_req   = 0;
    hold_seen  = 0;
    hold_cnt   = 0;
    fail_cnt   = 0;
    insn_cnt   = 0;
    result_cnt = 0;
    quiet_cnt  = 0;
    foreach (err_seen[i]) err_seen[i] = 0;
    foreach (vm_stack[i]) vm_stack[i] = '0;
    foreach (vm_static[i]) vm_static[i] = '0;
    vm_sp    = 0;
    vm_pc    = '0;
    vm_frame = '0;
    vm_len   = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);

    // directed: corners, errors and a mix of pushes, pops, arithmetic, compares and jumps
    cfg_write(CFG_FRAME_BASE, 16'd0);
    cfg_write(CFG_PROG_LEN, 16'hffff);
    add_insn(OP_ADD, 16'd0);
    add_insn(OP_NOT, 16'd0);
    add_insn(OP_PUSH_WORD, 16'h8000);
    add_insn(OP_DUP, 16'd0);
    add_insn(OP_MUL, 16'd0);
    add_insn(OP_PUSH_BYTE, 16'hff02);
    add_insn(OP_MUL, 16'd0);
    add_insn(OP_DUP, 16'd0);
    add_insn(OP_DUP, 16'd0);
    add_insn(OP_PUSH_BYTE, 16'd1);
    add_insn(OP_NEG, 16'd0);
    add_insn(OP_DIV, 16'd0);
    add_insn(OP_PUSH_BYTE, 16'd1);
    add_insn(OP_NEG, 16'd0);
    add_insn(OP_MOD, 16'd0);
    add_insn(OP_PUSH_BYTE, 16'd0);
    add_insn(OP_DIV, 16'd0);
    add_insn(OP_POP_STAT, 16'd255);
    add_insn(OP_PUSH_STAT, 16'd256);
    add_insn(OP_PUSH_STAT, 16'hffff);
    add_insn(OP_PUSH_STAT, 16'd255);
    add_insn(OP_PUSH_LOC, 16'd900);
    add_insn(OP_GE, 16'd0);
    add_insn(OP_JMP_T, 16'h1234);
    add_insn(OP_UNUSED, 16'hffff);
    drain();

    // fill the stack for overflow, local range limit at the top frame slot
    cfg_write(CFG_FRAME_BASE, 16'd1023);
    for (int i = 0; i < STK_N + 4; i++) add_insn(OP_PUSH_BYTE, 16'($urandom_range(0, 65535)));
    add_insn(OP_DUP, 16'd0);
    add_insn(OP_PUSH_LOC, 16'd1);
    add_insn(OP_POP_LOC, 16'd0);
    add_insn(OP_PUSH_LOC, 16'd0);
    for (int i = 0; i < FILL_OPS; i++) add_insn(5'($urandom_range(OP_ADD, OP_MUL)), 16'd0);
    drain();

    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin cfg_write(CFG_FRAME_BASE, 16'd0); cfg_write(CFG_PROG_LEN, 16'hffff); end
        1: begin cfg_write(CFG_FRAME_BASE, 16'd1023); cfg_write(CFG_PROG_LEN, 16'hffff); end
        2: begin
          cfg_write(CFG_FRAME_BASE, 16'($urandom_range(0, 1023)));
          cfg_write(CFG_PROG_LEN, 16'($urandom_range(0, 65535)));
        end
        3: begin cfg_write(CFG_FRAME_BASE, 16'd5); cfg_write(CFG_PROG_LEN, 16'd40); end
        4: begin cfg_write(CFG_FRAME_BASE, 16'd0); cfg_write(CFG_PROG_LEN, 16'd0); end
        default: begin
          cfg_write(CFG_FRAME_BASE, 16'($urandom_range(0, 1023)));
          cfg_write(CFG_PROG_LEN, 16'hffff);
        end
      endcase
      case (p % 4)
        0: begin snd_idle = 0;  rcv_idle = 0;  end
        1: begin snd_idle = 51; rcv_idle = 0;  end
        2: begin snd_idle = 0;  rcv_idle = 51; end
        default: begin snd_idle = 23; rcv_idle = 23; end
      endcase
      if (p == 0) hold_req++;
      for (int i = 0; i < RAND_N; i++) add_random();
      drain();
    end

    $display("Ran %0d instructions, %0d results checked, over fill, drain and six random phases",
             insn_cnt, result_cnt);
    $display("Errors seen: ok %0d div0 %0d under %0d over %0d static %0d",
             err_seen[0], err_seen[1], err_seen[2], err_seen[3], err_seen[4]);
    if (fail_cnt == 0 && result_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
